// ===== rtl/core/link_frame_check_fault_monitor_core_assert.svh =====
// ----------------------------------------------------------------------------
// Link frame check fault monitor: assertion macros
// Clocked assertion wrappers shared by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef LINK_FRAME_CHECK_FAULT_MONITOR_CORE_ASSERT_SVH
`define LINK_FRAME_CHECK_FAULT_MONITOR_CORE_ASSERT_SVH

// Checked on every edge outside reset.
`define LFCFM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define LFCFM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lfcfm_pkg.sv =====
// ----------------------------------------------------------------------------
// lfcfm_pkg
// Types, register map and frame helpers for the link frame check monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfcfm_pkg;

   localparam int FRAME_BYTES = 8;
   localparam int FRAME_W     = FRAME_BYTES * 8;

   // reset values of the control registers
   localparam logic [7:0]  HEADER_RST  = 8'd0;
   localparam logic [7:0]  LIMIT_RST   = 8'd5;
   localparam logic [31:0] TIMEOUT_RST = 32'd100;
   localparam logic [7:0]  GRACE_RST   = 8'd10;
   localparam logic [7:0]  SAFE_RST    = 8'd0;

   typedef enum logic [2:0] {
      REG_HEADER_VALUE  = 3'd0,
      REG_FAIL_LIMIT    = 3'd1,
      REG_TIMEOUT_TICKS = 3'd2,
      REG_GRACE_CYCLES  = 3'd3,
      REG_SAFE_TARGET   = 3'd4,
      REG_SAFE_MODE     = 3'd5,
      REG_SAFE_ALARM    = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_GOOD    = 2'd1,
      ST_BAD     = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   typedef struct packed {
      logic               link_busy;
      logic [31:0]        now_tick;
      logic [FRAME_W-1:0] received_frame;
      logic [FRAME_W-1:0] outgoing_payload;
   } req_payload_type;

   typedef struct packed {
      logic               dispatched;
      logic [FRAME_W-1:0] sealed_frame;
      logic               force_reset;
      logic [FRAME_W-1:0] committed_frame;
      logic               comm_fault;
      status_type         check_status;
   } rsp_payload_type;

   // XOR of every byte except the checksum byte
   function automatic logic [7:0] frame_xor(input logic [FRAME_W-1:0] f);
      logic [7:0] x;
      x = 8'd0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         x = x ^ f[i*8 +: 8];
      end
      return x;
   endfunction

endpackage

// ===== rtl/core/link_frame_check_fault_monitor_core.sv =====
// ----------------------------------------------------------------------------
// link_frame_check_fault_monitor_core
// Per-tick link watchdog: timeout, received frame check, fault tracking and
// sealing of the outgoing frame with header and XOR checksum.
// ----------------------------------------------------------------------------
// Result: a transaction accepted at one edge has its result valid after that
// edge, held in the result register until taken.
// Throughput: one transaction per cycle; req_ready stays high while the
// result register is empty or is being emptied in the same cycle.
// Reset (synchronous, active high): control registers to defaults, link
// state cleared, grace countdown loaded with its reset value, no result held.
`timescale 1ns / 1ps

`include "link_frame_check_fault_monitor_core_assert.svh"

module link_frame_check_fault_monitor_core
   import lfcfm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   // response channel
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   // APB control port
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [4:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   logic [7:0]  header_ff, limit_ff, grace_cyc_ff;
   logic [7:0]  safe_target_ff, safe_mode_ff, safe_alarm_ff;
   logic [31:0] timeout_ff;

   logic          csr_write;
   reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff      <= HEADER_RST;
         limit_ff       <= LIMIT_RST;
         timeout_ff     <= TIMEOUT_RST;
         grace_cyc_ff   <= GRACE_RST;
         safe_target_ff <= SAFE_RST;
         safe_mode_ff   <= SAFE_RST;
         safe_alarm_ff  <= SAFE_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_HEADER_VALUE:  header_ff      <= pwdata[7:0];
            REG_FAIL_LIMIT:    limit_ff       <= pwdata[7:0];
            REG_TIMEOUT_TICKS: timeout_ff     <= pwdata;
            REG_GRACE_CYCLES:  grace_cyc_ff   <= pwdata[7:0];
            REG_SAFE_TARGET:   safe_target_ff <= pwdata[7:0];
            REG_SAFE_MODE:     safe_mode_ff   <= pwdata[7:0];
            REG_SAFE_ALARM:    safe_alarm_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_HEADER_VALUE:  prdata = {24'd0, header_ff};
         REG_FAIL_LIMIT:    prdata = {24'd0, limit_ff};
         REG_TIMEOUT_TICKS: prdata = timeout_ff;
         REG_GRACE_CYCLES:  prdata = {24'd0, grace_cyc_ff};
         REG_SAFE_TARGET:   prdata = {24'd0, safe_target_ff};
         REG_SAFE_MODE:     prdata = {24'd0, safe_mode_ff};
         REG_SAFE_ALARM:    prdata = {24'd0, safe_alarm_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Link state
   // ---------------------------------------------------------------------
   logic               pending_ff, pending_in;
   logic [31:0]        start_ff, start_in;
   logic [7:0]         fail_ff, fail_in;
   logic [7:0]         grace_ff, grace_in;
   logic               fault_ff, fault_in;
   logic [FRAME_W-1:0] held_ff, held_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic req_fire;

   // result register frees up in the same cycle it is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Tick evaluation
   // ---------------------------------------------------------------------
   logic [31:0]        elapsed;
   logic               timed_out, busy_eff, do_check, frame_good;
   logic               fail_event, limit_hit, dispatch;
   logic [7:0]         fail_inc;
   logic [FRAME_W-1:0] sealed_base, sealed;
   status_type         status;

   always_comb begin
      elapsed   = req_data.now_tick - start_ff;
      timed_out = pending_ff && req_data.link_busy && (elapsed >= timeout_ff);
      // a timed out transfer leaves the link taken as idle
      busy_eff  = req_data.link_busy && !timed_out;
      do_check  = pending_ff && !req_data.link_busy;

      frame_good = (req_data.received_frame[7:0] == header_ff) &&
                   (req_data.received_frame[FRAME_W-1 -: 8] ==
                    frame_xor(req_data.received_frame));

      // at most one failure per tick: timeout and check are exclusive
      fail_event = (timed_out || (do_check && !frame_good)) && (grace_ff == 8'd0);
      fail_inc   = (fail_ff == 8'hFF) ? fail_ff : fail_ff + 8'd1;
      limit_hit  = fail_inc >= limit_ff;

      fail_in  = fail_ff;
      fault_in = fault_ff;
      held_in  = held_ff;
      status   = ST_NONE;

      if (timed_out) begin
         status = ST_TIMEOUT;
      end else if (do_check) begin
         status = frame_good ? ST_GOOD : ST_BAD;
      end

      if (do_check && frame_good) begin
         held_in  = req_data.received_frame;
         fail_in  = 8'd0;
         fault_in = 1'b0;
      end else if (fail_event) begin
         fail_in = fail_inc;
         if (limit_hit) begin
            fault_in = 1'b1;
            // safe defaults only on a bad frame, not on a timeout
            if (do_check) begin
               held_in = {held_ff[63:48], safe_alarm_ff, held_ff[39:32],
                          safe_mode_ff, safe_target_ff, held_ff[15:0]};
            end
         end
      end

      grace_in = (grace_ff != 8'd0) ? grace_ff - 8'd1 : grace_ff;

      // idle link, or a timeout: seal and send the next frame
      dispatch    = !busy_eff;
      pending_in  = dispatch || (pending_ff && busy_eff);
      start_in    = dispatch ? req_data.now_tick : start_ff;
      sealed_base = {req_data.outgoing_payload[FRAME_W-1:8], header_ff};
      sealed      = dispatch ?
                    {frame_xor(sealed_base), sealed_base[FRAME_W-9:0]} :
                    {FRAME_W{1'b0}};

      rsp_data_in.dispatched      = dispatch;
      rsp_data_in.sealed_frame    = sealed;
      rsp_data_in.force_reset     = timed_out;
      rsp_data_in.committed_frame = held_in;
      rsp_data_in.comm_fault      = fault_in;
      rsp_data_in.check_status    = status;

      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         start_ff     <= 32'd0;
         fail_ff      <= 8'd0;
         grace_ff     <= GRACE_RST;
         fault_ff     <= 1'b0;
         held_ff      <= {FRAME_W{1'b0}};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            pending_ff <= pending_in;
            start_ff   <= start_in;
            fail_ff    <= fail_in;
            grace_ff   <= grace_in;
            fault_ff   <= fault_in;
            held_ff    <= held_in;
         end else if (csr_write && csr_index == REG_GRACE_CYCLES) begin
            // writing the grace length restarts the countdown unless a transaction is accepted
            grace_ff <= pwdata[7:0];
         end
      end
   end

   // payload only; qualified by rsp_valid_ff
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `LFCFM_ASSERT(a_good_clears_fault, clock, reset,
      rsp_valid_ff && rsp_data_ff.check_status == ST_GOOD |-> !rsp_data_ff.comm_fault,
      "good frame result still reports a fault")
   `LFCFM_ASSERT(a_sealed_zero_idle, clock, reset,
      rsp_valid_ff && !rsp_data_ff.dispatched |-> rsp_data_ff.sealed_frame == 64'd0,
      "sealed frame nonzero without dispatch")
   `LFCFM_ASSERT(a_reset_means_timeout, clock, reset,
      rsp_valid_ff |-> rsp_data_ff.force_reset == (rsp_data_ff.check_status == ST_TIMEOUT),
      "force_reset and timeout status disagree")
   `LFCFM_ASSERT(a_dispatch_sets_pending, clock, reset,
      req_fire && dispatch |=> pending_ff,
      "dispatched frame left no pending transfer")
   `LFCFM_ASSERT_ALWAYS(a_reset_empties_rsp, clock,
      reset |=> !rsp_valid_ff,
      "result valid right after reset")

endmodule
